// ===== rtl/assert_macros.svh =====
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/pnu_pkg.sv =====
package pnu_pkg;

  localparam int DAMP_BITS          = 16;
  localparam int NODE_BITS          = 21;
  localparam int SUM_BITS           = 40;
  localparam int RANK_FRAC_BITS_DEF = 32;
  localparam int DEGREE_BITS_DEF    = 21;
  localparam int CFG_IDX_BITS       = 2;

  localparam logic [DAMP_BITS-1:0] DAMPING_RST    = 16'd55705;
  localparam logic [NODE_BITS-1:0] NODE_COUNT_RST = 21'd1;

  localparam logic KIND_SCALED = 1'b0;
  localparam logic KIND_RANK   = 1'b1;

  typedef enum logic [1:0] {
    CMD_SCALE  = 2'd0,
    CMD_ACCUM  = 2'd1,
    CMD_FINISH = 2'd2
  } cmd_t;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_DAMPING      = 2'd0,
    REG_BASE_TERM    = 2'd1,
    REG_DEAD_END_SUM = 2'd2,
    REG_NODE_COUNT   = 2'd3
  } reg_idx_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_DIV,
    ST_SUM,
    ST_DIFF,
    ST_PUSH
  } state_t;

  typedef struct packed {
    logic busy;
    logic done;
  } unit_stat_t;

endpackage

// ===== rtl/pnu_div.sv =====
module pnu_div #(
  parameter int DIVIDEND_W = 48,
  parameter int DIVISOR_W  = 21,
  localparam int CNT_W     = $clog2(DIVIDEND_W + 1)
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  input  logic [DIVIDEND_W-1:0]   dividend,
  input  logic [DIVISOR_W-1:0]    divisor,
  input  logic [CNT_W-1:0]        steps,
  output logic [DIVIDEND_W-1:0]   quotient,
  output pnu_pkg::unit_stat_t     stat
);

  // Restoring divider, one quotient bit per cycle. The dividend is taken
  // from the top of quo_r; quotient bits enter at the bottom.
  logic [DIVIDEND_W-1:0] quo_r, quo_nxt;
  logic [DIVISOR_W-1:0]  rem_r, rem_nxt;
  logic [DIVISOR_W-1:0]  dvs_r;
  logic [CNT_W-1:0]      cnt_r;
  logic                  busy_r;
  logic                  done_r;

  logic [DIVISOR_W:0] trial;
  logic [DIVISOR_W:0] trial_diff;
  logic               fits;

  always_comb begin
    trial      = {rem_r, quo_r[DIVIDEND_W-1]};
    fits       = trial >= {1'b0, dvs_r};
    trial_diff = trial - {1'b0, dvs_r};
    rem_nxt    = fits ? trial_diff[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];
    quo_nxt    = {quo_r[DIVIDEND_W-2:0], fits};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= steps;
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= dividend;
      rem_r <= '0;
      dvs_r <= divisor;
    end else if (busy_r) begin
      quo_r <= quo_nxt;
      rem_r <= rem_nxt;
    end
  end

  assign quotient  = quo_r;
  assign stat.busy = busy_r;
  assign stat.done = done_r;

endmodule

// ===== rtl/pnu_mul.sv =====
module pnu_mul #(
  parameter int A_W    = 32,
  parameter int B_W    = 16,
  localparam int CNT_W = $clog2(B_W + 1)
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  logic [A_W-1:0]       a,
  input  logic [B_W-1:0]       b,
  output logic [A_W+B_W-1:0]   product,
  output pnu_pkg::unit_stat_t  stat
);

  // Shift-add multiplier, one bit of b per cycle, MSB first.
  logic [A_W+B_W-1:0] acc_r, acc_nxt;
  logic [A_W-1:0]     a_r;
  logic [B_W-1:0]     b_r;
  logic [CNT_W-1:0]   cnt_r;
  logic               busy_r;
  logic               done_r;

  always_comb begin
    acc_nxt = {acc_r[A_W+B_W-2:0], 1'b0}
            + (b_r[B_W-1] ? {{B_W{1'b0}}, a_r} : '0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(B_W);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      acc_r <= '0;
      a_r   <= a;
      b_r   <= b;
    end else if (busy_r) begin
      acc_r <= acc_nxt;
      b_r   <= {b_r[B_W-2:0], 1'b0};
    end
  end

  assign product   = acc_r;
  assign stat.busy = busy_r;
  assign stat.done = done_r;

endmodule

// ===== rtl/pagerank_node_update.sv =====
// Scale: the bit-serial divider divides the rank by the degree; a dead end (degree 0)
//   skips the divider and goes straight to the output. Accumulate: updates the sum only.
// Finish: serial damping multiply, then one divider bit per cycle, then
//   add/saturate/difference.
// One item in flight; the next is accepted once the result moves to the output register.
// Reset (rst_n low, synchronous): registers take their reset values, sum cleared.
`include "assert_macros.svh"

module pagerank_node_update #(
  parameter int RANK_FRAC_BITS = pnu_pkg::RANK_FRAC_BITS_DEF,
  parameter int DEGREE_BITS    = pnu_pkg::DEGREE_BITS_DEF,
  localparam int RANK_W = RANK_FRAC_BITS,
  localparam int CFG_W  = (RANK_W > pnu_pkg::NODE_BITS) ? RANK_W : pnu_pkg::NODE_BITS
) (
  input  logic                              clk,
  input  logic                              rst_n,

  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [1:0]                        in_command,
  input  logic [RANK_W-1:0]                 in_rank_value,
  input  logic [DEGREE_BITS-1:0]            in_out_degree,
  input  logic [RANK_W-1:0]                 in_old_rank,

  output logic                              out_valid,
  input  logic                              out_ready,
  output logic                              out_result_kind,
  output logic [RANK_W-1:0]                 out_value,
  output logic [RANK_W-1:0]                 out_error,
  output logic                              out_dead_end,

  input  logic                              cfg_we,
  input  logic [pnu_pkg::CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [CFG_W-1:0]                  cfg_data
);

  localparam int DAMP_BITS  = pnu_pkg::DAMP_BITS;
  localparam int NODE_BITS  = pnu_pkg::NODE_BITS;
  localparam int SUM_BITS   = pnu_pkg::SUM_BITS;
  localparam int DIVIDEND_W = RANK_W + DAMP_BITS;
  localparam int DIVISOR_W  = (DEGREE_BITS > NODE_BITS) ? DEGREE_BITS : NODE_BITS;
  localparam int DCNT_W     = $clog2(DIVIDEND_W + 1);
  localparam int ACC_W      = ((SUM_BITS > RANK_W) ? SUM_BITS : RANK_W) + 1;
  localparam int PN_W       = SUM_BITS + DAMP_BITS;
  localparam int NW_W       = ((SUM_BITS > RANK_W) ? SUM_BITS : RANK_W) + 2;

  localparam logic [SUM_BITS-1:0] SUM_MAX  = {SUM_BITS{1'b1}};
  localparam logic [RANK_W-1:0]   RANK_MAX = {RANK_W{1'b1}};

  // Configuration registers
  logic [DAMP_BITS-1:0] damping_r;
  logic [RANK_W-1:0]    base_term_r;
  logic [RANK_W-1:0]    dead_end_sum_r;
  logic [NODE_BITS-1:0] node_count_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      damping_r      <= pnu_pkg::DAMPING_RST;
      base_term_r    <= '0;
      dead_end_sum_r <= '0;
      node_count_r   <= pnu_pkg::NODE_COUNT_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        pnu_pkg::REG_DAMPING:      damping_r      <= cfg_data[DAMP_BITS-1:0];
        pnu_pkg::REG_BASE_TERM:    base_term_r    <= cfg_data[RANK_W-1:0];
        pnu_pkg::REG_DEAD_END_SUM: dead_end_sum_r <= cfg_data[RANK_W-1:0];
        pnu_pkg::REG_NODE_COUNT:   node_count_r   <= cfg_data[NODE_BITS-1:0];
      endcase
    end
  end

  pnu_pkg::state_t state_r, state_nxt;

  logic in_fire;
  logic out_load;
  logic out_valid_r;

  // Neighbour sum
  logic [SUM_BITS-1:0] sum_r;
  logic [ACC_W-1:0]    acc_sum;

  assign acc_sum = ACC_W'(sum_r) + ACC_W'(in_rank_value);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r <= '0;
    end else if (in_fire) begin
      if (in_command == pnu_pkg::CMD_ACCUM) begin
        sum_r <= (acc_sum > ACC_W'(SUM_MAX)) ? SUM_MAX : acc_sum[SUM_BITS-1:0];
      end else if (in_command == pnu_pkg::CMD_FINISH) begin
        sum_r <= '0;
      end
    end
  end

  // Arithmetic units
  logic                    mul_start;
  logic [DIVIDEND_W-1:0]   p_s;
  logic [PN_W-1:0]         p_n;
  pnu_pkg::unit_stat_t     mul_s_stat;
  pnu_pkg::unit_stat_t     mul_n_stat;

  pnu_mul #(.A_W(RANK_W), .B_W(DAMP_BITS)) u_mul_s (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (mul_start),
    .a       (dead_end_sum_r),
    .b       (damping_r),
    .product (p_s),
    .stat    (mul_s_stat)
  );

  pnu_mul #(.A_W(SUM_BITS), .B_W(DAMP_BITS)) u_mul_n (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (mul_start),
    .a       (sum_r),
    .b       (damping_r),
    .product (p_n),
    .stat    (mul_n_stat)
  );

  logic                    div_start;
  logic [DIVIDEND_W-1:0]   div_dividend;
  logic [DIVISOR_W-1:0]    div_divisor;
  logic [DCNT_W-1:0]       div_steps;
  logic [DIVIDEND_W-1:0]   quotient;
  pnu_pkg::unit_stat_t     div_stat;

  pnu_div #(.DIVIDEND_W(DIVIDEND_W), .DIVISOR_W(DIVISOR_W)) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .steps    (div_steps),
    .quotient (quotient),
    .stat     (div_stat)
  );

  logic [NODE_BITS-1:0] n_eff;
  assign n_eff = (node_count_r == '0) ? NODE_BITS'(1) : node_count_r;

  // Sequencer
  assign in_ready = (state_r == pnu_pkg::ST_IDLE);
  assign in_fire  = in_valid && in_ready;

  logic fin_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= pnu_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt    = state_r;
    mul_start    = 1'b0;
    div_start    = 1'b0;
    out_load     = 1'b0;
    // scale: dividend left-aligned, one step per rank bit
    div_dividend = {in_rank_value, {DAMP_BITS{1'b0}}};
    div_divisor  = DIVISOR_W'(in_out_degree);
    div_steps    = DCNT_W'(RANK_W);
    unique case (state_r)
      pnu_pkg::ST_IDLE: begin
        if (in_valid) begin
          unique case (in_command)
            pnu_pkg::CMD_SCALE: begin
              if (in_out_degree == '0) begin
                state_nxt = pnu_pkg::ST_PUSH;
              end else begin
                div_start = 1'b1;
                state_nxt = pnu_pkg::ST_DIV;
              end
            end
            pnu_pkg::CMD_FINISH: begin
              mul_start = 1'b1;
              state_nxt = pnu_pkg::ST_MUL;
            end
            default: ;
          endcase
        end
      end
      pnu_pkg::ST_MUL: begin
        if (mul_s_stat.done) begin
          div_start    = 1'b1;
          div_dividend = p_s;
          div_divisor  = DIVISOR_W'(n_eff);
          div_steps    = DCNT_W'(DIVIDEND_W);
          state_nxt    = pnu_pkg::ST_DIV;
        end
      end
      pnu_pkg::ST_DIV: begin
        if (div_stat.done) begin
          state_nxt = fin_r ? pnu_pkg::ST_SUM : pnu_pkg::ST_PUSH;
        end
      end
      pnu_pkg::ST_SUM:  state_nxt = pnu_pkg::ST_DIFF;
      pnu_pkg::ST_DIFF: state_nxt = pnu_pkg::ST_PUSH;
      pnu_pkg::ST_PUSH: begin
        if (!out_valid_r || out_ready) begin
          out_load  = 1'b1;
          state_nxt = pnu_pkg::ST_IDLE;
        end
      end
      default: state_nxt = pnu_pkg::ST_IDLE;
    endcase
  end

  // Finish datapath: base + (d*S/N >> 16) + (d*sum >> 16), saturate, |new - old|
  logic [NW_W-1:0]   nw_full;
  logic [RANK_W-1:0] nw_r;
  logic [RANK_W-1:0] old_r;
  logic [RANK_W:0]   d_up;
  logic [RANK_W-1:0] d_dn;
  logic [RANK_W-1:0] err_abs;

  assign nw_full = NW_W'(base_term_r)
                 + NW_W'(quotient[DIVIDEND_W-1:DAMP_BITS])
                 + NW_W'(p_n[PN_W-1:DAMP_BITS]);
  assign d_up    = {1'b0, nw_r} - {1'b0, old_r};
  assign d_dn    = old_r - nw_r;
  assign err_abs = d_up[RANK_W] ? d_dn : d_up[RANK_W-1:0];

  logic              res_kind_r;
  logic [RANK_W-1:0] res_val_r;
  logic [RANK_W-1:0] res_err_r;
  logic              res_dead_r;

  always_ff @(posedge clk) begin
    if (in_fire) begin
      fin_r      <= (in_command == pnu_pkg::CMD_FINISH);
      old_r      <= in_old_rank;
      // dead end result; overwritten by the divider path otherwise
      res_kind_r <= pnu_pkg::KIND_SCALED;
      res_val_r  <= '0;
      res_err_r  <= '0;
      res_dead_r <= 1'b1;
    end
    if (state_r == pnu_pkg::ST_DIV && div_stat.done && !fin_r) begin
      res_val_r  <= quotient[RANK_W-1:0];
      res_dead_r <= 1'b0;
    end
    if (state_r == pnu_pkg::ST_SUM) begin
      nw_r <= (nw_full > NW_W'(RANK_MAX)) ? RANK_MAX : nw_full[RANK_W-1:0];
    end
    if (state_r == pnu_pkg::ST_DIFF) begin
      res_kind_r <= pnu_pkg::KIND_RANK;
      res_val_r  <= nw_r;
      res_err_r  <= err_abs;
      res_dead_r <= 1'b0;
    end
  end

  // Output register
  logic              out_kind_r;
  logic [RANK_W-1:0] out_value_r;
  logic [RANK_W-1:0] out_error_r;
  logic              out_dead_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_kind_r  <= res_kind_r;
      out_value_r <= res_val_r;
      out_error_r <= res_err_r;
      out_dead_r  <= res_dead_r;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_result_kind = out_kind_r;
  assign out_value       = out_value_r;
  assign out_error       = out_error_r;
  assign out_dead_end    = out_dead_r;

  `ASSERT_SAME(a_mul_in_step, mul_s_stat.done || mul_n_stat.done,
    mul_s_stat.done && mul_n_stat.done, "multipliers out of step")
  `ASSERT_SAME(a_div_idle_start, div_start, !div_stat.busy, "divider started while busy")
  `ASSERT_NEXT(a_sum_cleared, in_fire && (in_command == pnu_pkg::CMD_FINISH),
    sum_r == '0, "neighbour sum not cleared after finish")
  `ASSERT_SAME(a_dead_end_beat, out_valid_r && out_dead_r,
    (out_value_r == '0) && (out_kind_r == pnu_pkg::KIND_SCALED), "bad dead end beat")

endmodule

// ===== bench/node_update_checker.sv =====
`timescale 1ns / 100ps

module node_update_checker
  import pnu_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,

  input  logic                     in_valid,
  input  logic                     in_ready,
  input  logic [1:0]               in_command,
  input  logic [31:0]              in_rank_value,
  input  logic [20:0]              in_out_degree,
  input  logic [31:0]              in_old_rank,

  input  logic                     out_valid,
  input  logic                     out_ready,
  input  logic                     out_result_kind,
  input  logic [31:0]              out_value,
  input  logic [31:0]              out_error,
  input  logic                     out_dead_end,

  input  logic                     cfg_we,
  input  logic [CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [31:0]              cfg_data,

  output int                       mismatches,
  output int                       pending,
  output int                       scaled_seen,
  output int                       dead_seen,
  output int                       ranks_seen
);

  localparam int RANK_W = RANK_FRAC_BITS_DEF;
  localparam logic [63:0] RANK_MAX = (64'd1 << RANK_W) - 64'd1;
  localparam logic [63:0] SUM_SAT  = (64'd1 << SUM_BITS) - 64'd1;

  typedef struct packed {
    logic              kind;
    logic [RANK_W-1:0] value;
    logic [RANK_W-1:0] err;
    logic              dead;
  } node_result_t;

  node_result_t expected_q[$];

  // local copy of the block's registers and running sum
  logic [DAMP_BITS-1:0] damping_r;
  logic [RANK_W-1:0]    base_r;
  logic [RANK_W-1:0]    dead_sum_r;
  logic [NODE_BITS-1:0] nodes_r;
  logic [63:0]          nbr_sum;

  task automatic predict_update(input logic [1:0] cmd, input logic [RANK_W-1:0] rv,
                                input logic [20:0] deg, input logic [RANK_W-1:0] old);
    node_result_t r;
    logic [63:0]  n, t2, t3, nw, s;
    r = '0;
    case (cmd)
      CMD_SCALE: begin
        r.kind = KIND_SCALED;
        if (deg == '0) r.dead = 1'b1;
        else r.value = rv / deg;
        expected_q.push_back(r);
      end
      CMD_ACCUM: begin
        s = nbr_sum + 64'(rv);
        nbr_sum = (s > SUM_SAT) ? SUM_SAT : s;
      end
      CMD_FINISH: begin
        n  = (nodes_r == '0) ? 64'd1 : 64'(nodes_r);
        t2 = ((64'(damping_r) * 64'(dead_sum_r)) / n) >> DAMP_BITS;
        t3 = (64'(damping_r) * nbr_sum) >> DAMP_BITS;
        nw = 64'(base_r) + t2 + t3;
        if (nw > RANK_MAX) nw = RANK_MAX;
        r.kind  = KIND_RANK;
        r.value = nw[RANK_W-1:0];
        r.err   = (nw >= 64'(old)) ? RANK_W'(nw - 64'(old)) : RANK_W'(64'(old) - nw);
        nbr_sum = '0;
        expected_q.push_back(r);
      end
      default: ;
    endcase
  endtask

  task automatic check_field(input string name, input logic [63:0] want,
                             input logic [63:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %h, got %h", $time, name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    node_result_t want;
    if (!rst_n) begin
      damping_r   = DAMPING_RST;
      base_r      = '0;
      dead_sum_r  = '0;
      nodes_r     = NODE_COUNT_RST;
      nbr_sum     = '0;
      mismatches  = 0;
      scaled_seen = 0;
      dead_seen   = 0;
      ranks_seen  = 0;
      expected_q.delete();
    end else begin
      // retire the output beat before taking a new input beat
      if (out_valid && out_ready) begin
        if (expected_q.size() == 0) begin
          $display("%0t: unexpected result beat, kind %b value %h error %h dead %b",
                   $time, out_result_kind, out_value, out_error, out_dead_end);
          mismatches++;
        end else begin
          want = expected_q.pop_front();
          check_field("result_kind", 64'(want.kind), 64'(out_result_kind));
          check_field("value", 64'(want.value), 64'(out_value));
          check_field("error", 64'(want.err), 64'(out_error));
          check_field("dead_end", 64'(want.dead), 64'(out_dead_end));
          if (want.kind == KIND_RANK) ranks_seen++;
          else scaled_seen++;
          if (want.dead) dead_seen++;
        end
      end
      if (in_valid && in_ready)
        predict_update(in_command, in_rank_value, in_out_degree, in_old_rank);
      if (cfg_we) begin
        case (cfg_index)
          REG_DAMPING:      damping_r  = cfg_data[DAMP_BITS-1:0];
          REG_BASE_TERM:    base_r     = cfg_data[RANK_W-1:0];
          REG_DEAD_END_SUM: dead_sum_r = cfg_data[RANK_W-1:0];
          REG_NODE_COUNT:   nodes_r    = cfg_data[NODE_BITS-1:0];
          default: ;
        endcase
      end
    end
    pending = expected_q.size();
  end

endmodule

// ===== bench/testbench.sv =====
`timescale 1ns / 100ps

module testbench;
  import pnu_pkg::*;

  localparam int RANK_W        = RANK_FRAC_BITS_DEF;
  localparam int DEG_W         = DEGREE_BITS_DEF;
  localparam int CFG_W         = (RANK_W > NODE_BITS) ? RANK_W : NODE_BITS;
  localparam int MAX_DEGREE    = 1048576;
  localparam int SETTLE_CYCLES = 80;
  localparam int STALL_LIMIT   = 2000;
  localparam int PHASE_ITEMS   = 16;
  localparam logic [1:0] CMD_UNUSED = 2'd3;

  logic                    clk = 1'b0;
  logic                    rst_n;
  logic                    in_valid, in_ready;
  logic [1:0]              in_command;
  logic [RANK_W-1:0]       in_rank_value, in_old_rank;
  logic [DEG_W-1:0]        in_out_degree;
  logic                    out_valid, out_ready;
  logic                    out_result_kind, out_dead_end;
  logic [RANK_W-1:0]       out_value, out_error;
  logic                    cfg_we;
  logic [CFG_IDX_BITS-1:0] cfg_index;
  logic [CFG_W-1:0]        cfg_data;

  int mismatches, pending, scaled_seen, dead_seen, ranks_seen;
  int items_sent = 0;
  int cmd_count[4] = '{0, 0, 0, 0};
  int settings = 1;
  int stall_left = 0;
  int quiet_cycles = 0;
  bit calm = 1'b0;

  always #1 clk = ~clk;

  pagerank_node_update DUT (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_command(in_command),
    .in_rank_value(in_rank_value), .in_out_degree(in_out_degree), .in_old_rank(in_old_rank),
    .out_valid(out_valid), .out_ready(out_ready), .out_result_kind(out_result_kind),
    .out_value(out_value), .out_error(out_error), .out_dead_end(out_dead_end),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  node_update_checker rank_check (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_command(in_command),
    .in_rank_value(in_rank_value), .in_out_degree(in_out_degree), .in_old_rank(in_old_rank),
    .out_valid(out_valid), .out_ready(out_ready), .out_result_kind(out_result_kind),
    .out_value(out_value), .out_error(out_error), .out_dead_end(out_dead_end),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .mismatches(mismatches), .pending(pending), .scaled_seen(scaled_seen),
    .dead_seen(dead_seen), .ranks_seen(ranks_seen)
  );

  // mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 80);
  endfunction

  function automatic logic [RANK_W-1:0] rand_rank();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      2: return RANK_W'($urandom_range(0, 255));
      3: return {1'b1, 31'($urandom)};
      default: return RANK_W'($urandom);
    endcase
  endfunction

  function automatic logic [DEG_W-1:0] rand_degree();
    int r;
    r = $urandom_range(0, 99);
    if (r < 10) return '0;
    if (r < 18) return DEG_W'(MAX_DEGREE);
    if (r < 26) return DEG_W'(1);
    if (r < 40) return DEG_W'($urandom_range(1, MAX_DEGREE));
    return DEG_W'($urandom_range(2, 300));
  endfunction

  function automatic logic [DEG_W-1:0] any_degree();
    return DEG_W'($urandom_range(0, MAX_DEGREE));
  endfunction

  // result side: random stall bursts unless calm
  always @(posedge clk) begin
    if (calm) begin
      out_ready <= 1'b1;
    end else if (stall_left > 0) begin
      out_ready <= 1'b0;
      stall_left--;
    end else begin
      out_ready <= 1'b1;
      if ($urandom_range(0, 99) < 20) stall_left = pick_gap() + 1;
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("%0t: no beat for %0d cycles, %0d results outstanding",
                 $time, quiet_cycles, pending);
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  // valid stays up between back-to-back beats; send_item lowers it only for a gap
  task automatic send_item(input logic [1:0] cmd, input logic [RANK_W-1:0] rv,
                           input logic [DEG_W-1:0] deg, input logic [RANK_W-1:0] old);
    int gap;
    gap = calm ? 0 : pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_command    <= cmd;
    in_rank_value <= rv;
    in_out_degree <= deg;
    in_old_rank   <= old;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    items_sent++;
    cmd_count[cmd]++;
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    do @(negedge clk); while (pending != 0);
    @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_config(input logic [CFG_W-1:0] damp, input logic [CFG_W-1:0] base,
                              input logic [CFG_W-1:0] dsum, input logic [CFG_W-1:0] nodes);
    cfg_we    <= 1'b1;
    cfg_index <= REG_DAMPING;
    cfg_data  <= damp;
    @(posedge clk);
    cfg_index <= REG_BASE_TERM;
    cfg_data  <= base;
    @(posedge clk);
    cfg_index <= REG_DEAD_END_SUM;
    cfg_data  <= dsum;
    @(posedge clk);
    cfg_index <= REG_NODE_COUNT;
    cfg_data  <= nodes;
    @(posedge clk);
    cfg_we <= 1'b0;
    settings++;
  endtask

  // accumulate a few neighbours, then finish the node
  task automatic node_sequence();
    repeat ($urandom_range(0, 6)) send_item(CMD_ACCUM, rand_rank(), any_degree(), rand_rank());
    send_item(CMD_FINISH, rand_rank(), any_degree(), rand_rank());
  endtask

  task automatic random_item();
    int r;
    r = $urandom_range(0, 99);
    if (r < 40) begin
      send_item(CMD_SCALE, rand_rank(), rand_degree(), rand_rank());
    end else if (r < 92) begin
      node_sequence();
    end else if (r < 97) begin
      send_item(CMD_UNUSED, RANK_W'($urandom), any_degree(), RANK_W'($urandom));
    end else begin
      // broken sequence: a scale lands between an accumulate and the next finish
      send_item(CMD_ACCUM, rand_rank(), any_degree(), rand_rank());
      send_item(CMD_SCALE, rand_rank(), rand_degree(), rand_rank());
    end
  endtask

  task automatic run_phase();
    int target;
    target = items_sent + PHASE_ITEMS;
    while (items_sent < target - PHASE_ITEMS / 2) random_item();
    drain_results();
    while (items_sent < target) random_item();
  endtask

  function automatic logic [CFG_W-1:0] rand_node_count();
    int r;
    r = $urandom_range(0, 99);
    if (r < 15) return {11'($urandom), 21'd0};
    if (r < 30) return {11'($urandom), 21'(MAX_DEGREE)};
    return {11'($urandom), 21'($urandom_range(1, MAX_DEGREE))};
  endfunction

  initial begin
    rst_n         = 1'b0;
    in_valid      = 1'b0;
    in_command    = CMD_SCALE;
    in_rank_value = '0;
    in_out_degree = '0;
    in_old_rank   = '0;
    out_ready     = 1'b0;
    cfg_we        = 1'b0;
    cfg_index     = REG_DAMPING;
    cfg_data      = '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed, on reset register values
    send_item(CMD_SCALE, '0, DEG_W'(1), '0);
    send_item(CMD_SCALE, '1, DEG_W'(1), '1);
    send_item(CMD_SCALE, '1, DEG_W'(MAX_DEGREE), '0);
    send_item(CMD_SCALE, 32'h1234_5678, '0, '0);          // dead end
    send_item(CMD_SCALE, '0, '0, '1);                     // dead end, zero rank
    send_item(CMD_SCALE, 32'hDEAD_BEEF, DEG_W'(MAX_DEGREE - 1), '0);
    send_item(CMD_SCALE, '1, DEG_W'(3), '0);
    send_item(CMD_UNUSED, '1, DEG_W'(MAX_DEGREE), '1);
    send_item(CMD_FINISH, '0, '0, '0);                    // empty sum
    send_item(CMD_FINISH, '0, '0, '1);                    // old above new
    send_item(CMD_ACCUM, '1, '0, '0);
    send_item(CMD_ACCUM, '1, '0, '0);
    send_item(CMD_ACCUM, RANK_W'(1), '0, '0);
    send_item(CMD_FINISH, '0, '0, '1);                    // new rank saturates
    send_item(CMD_ACCUM, 32'h8000_0000, '0, '0);
    send_item(CMD_FINISH, '0, '0, '0);
    send_item(CMD_ACCUM, 32'h0001_0000, '0, '0);
    send_item(CMD_FINISH, '0, '0, 32'h7FFF_FFFF);
    send_item(CMD_UNUSED, '0, '0, '0);
    send_item(CMD_ACCUM, '0, '0, '0);
    send_item(CMD_FINISH, '0, '0, RANK_W'(1));
    run_phase();

    for (int p = 0; p < 8; p++) begin
      drain_results();
      calm = (p == 2 || p == 5);
      case (p)
        0: write_config(CFG_W'(16'hFFFF), '1, '1, CFG_W'(1));
        1: write_config('0, '0, '0, '0);                 // zero node count
        2: write_config(CFG_W'($urandom), CFG_W'($urandom >> 4), CFG_W'($urandom),
                        CFG_W'(MAX_DEGREE));
        3: write_config({16'hBEEF, 16'd200}, '0, '1, 32'hFFE0_0003);
        default: write_config(CFG_W'($urandom), CFG_W'($urandom >> $urandom_range(0, 31)),
                              CFG_W'($urandom), rand_node_count());
      endcase
      if (p == 3) begin
        // push the running sum past its ceiling; small damping keeps it visible
        repeat (260) send_item(CMD_ACCUM, '1 - RANK_W'($urandom_range(0, 3)),
                               any_degree(), rand_rank());
        send_item(CMD_FINISH, rand_rank(), any_degree(), rand_rank());
      end
      run_phase();
    end

    calm = 1'b0;
    drain_results();
    $display("Sent %0d items (%0d scale, %0d accumulate, %0d finish, %0d unused) over %0d settings",
             items_sent, cmd_count[0], cmd_count[1], cmd_count[2], cmd_count[3], settings);
    $display("Checked %0d scaled values (%0d dead ends) and %0d new ranks",
             scaled_seen, dead_seen, ranks_seen);
    if (mismatches == 0 && pending == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
